FILE: design/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, item codes and types for the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  localparam int COL_W  = $clog2(COLUMNS);      // cursor / cell column
  localparam int LEN_W  = $clog2(COLUMNS + 1);  // column count 0..COLUMNS
  localparam int ROW_W  = $clog2(ROWS);         // cursor / cell row
  localparam int ROWC_W = $clog2(ROWS + 1);     // row count 0..ROWS
  localparam int ADDR_W = $clog2(CELLS);

  // Stream field widths
  localparam int CHAR_W     = 8;
  localparam int F_ROW_W    = 5;
  localparam int F_COL_W    = 7;
  localparam int IN_TDATA_W = 24;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_PAD_W  = OUT_TDATA_W - (F_COL_W + F_ROW_W + CHAR_W + 1);

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;

  // op as carried on in_tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Request classes handed from front to back
  typedef logic [1:0] tcw_kind_t;
  localparam tcw_kind_t KIND_CHAR     = 2'd0;
  localparam tcw_kind_t KIND_NEWLINE  = 2'd1;
  localparam tcw_kind_t KIND_READ     = 2'd2;
  localparam tcw_kind_t KIND_READ_OOR = 2'd3;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    tcw_kind_t           kind;
    logic [CHAR_W-1:0]   char_code;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ROW_W-1:0]    rd_row;
    logic [COL_W-1:0]    rd_col;
  } tcw_item_t;

endpackage

`default_nettype wire

FILE: design/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: design/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front
// Accepts stream requests, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_front import tcw_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output      logic                  in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,  // char_code[7:0] read_row[12:8] read_col[19:13]
  input  wire logic                  in_tuser,  // op
  output      logic                  q_valid,
  output      tcw_item_t             q_item,
  input  wire logic                  q_pop
);

  logic [CHAR_W-1:0]  f_char;
  logic [F_ROW_W-1:0] f_row;
  logic [F_COL_W-1:0] f_col;
  logic               in_range;
  tcw_item_t          cls;

  tcw_item_t          q_mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               push;

  assign f_char = in_tdata[7:0];
  assign f_row  = in_tdata[12:8];
  assign f_col  = in_tdata[19:13];

  assign in_range = (int'(f_row) < ROWS) && (int'(f_col) < COLUMNS);

  always_comb begin
    cls.char_code = f_char;
    cls.rd_addr   = '0;
    cls.rd_row    = '0;
    cls.rd_col    = '0;
    if (in_tuser == OP_READ) begin
      if (in_range) begin
        cls.kind    = KIND_READ;
        cls.rd_row  = ROW_W'(f_row);
        cls.rd_col  = COL_W'(f_col);
        cls.rd_addr = ADDR_W'(int'(f_row) * COLUMNS + int'(f_col));
      end else begin
        cls.kind = KIND_READ_OOR;
      end
    end else if (f_char == NEWLINE_CODE) begin
      cls.kind = KIND_NEWLINE;
    end else begin
      cls.kind = KIND_CHAR;
    end
  end

  assign in_tready = (int'(cnt_r) != QDEPTH);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign q_item    = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) <= QDEPTH)
    else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

FILE: design/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back
// Executes queued requests: cursor, character store and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_back import tcw_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   q_valid,
  input  wire tcw_item_t              q_item,
  output      logic                   q_pop,
  output      logic                   out_tvalid,
  input  wire logic                   out_tready,
  output      logic [OUT_TDATA_W-1:0] out_tdata  // cursor_col[6:0] cursor_row[11:7]
                                                 // read_char[19:12] screen_cleared[20]
);

  // Cursor and per-row written length. A cell is live only if it was written
  // since the last clear; anything else reads as a space.
  logic [COL_W-1:0]  cur_x_r, cur_x_nxt;
  logic [ROW_W-1:0]  cur_y_r, cur_y_nxt;
  logic [ADDR_W-1:0] row_base_r, row_base_nxt;
  logic [LEN_W-1:0]  len_r [ROWS];

  logic              s2_valid_r;
  logic [COL_W-1:0]  s2_x_r;
  logic [ROW_W-1:0]  s2_y_r;
  logic              s2_cleared_r;
  logic              s2_use_mem_r;
  logic [CHAR_W-1:0] s2_char_r;

  logic [LEN_W-1:0]  x_inc;
  logic [ROWC_W-1:0] y_inc;
  logic              row_end;
  logic              clear;
  logic              wr_char;
  logic              rd_hit;
  logic              use_mem;
  logic [CHAR_W-1:0] fixed_char;
  logic [LEN_W-1:0]  len_wdata;
  logic              ram_we, ram_re;
  logic [CHAR_W-1:0] ram_rdata;
  logic [CHAR_W-1:0] read_char;

  assign q_pop = q_valid && (!s2_valid_r || out_tready);

  assign x_inc = LEN_W'(cur_x_r) + LEN_W'(1);
  assign y_inc = ROWC_W'(cur_y_r) + ROWC_W'(1);

  assign rd_hit = ((q_item.rd_row < cur_y_r) && (LEN_W'(q_item.rd_col) < len_r[q_item.rd_row]))
               || ((q_item.rd_row == cur_y_r) && (q_item.rd_col < cur_x_r));

  always_comb begin
    row_end    = 1'b0;
    wr_char    = 1'b0;
    use_mem    = 1'b0;
    fixed_char = '0;
    len_wdata  = '0;
    unique case (q_item.kind)
      KIND_CHAR: begin
        wr_char = 1'b1;
        if (x_inc == LEN_W'(COLUMNS)) begin
          row_end   = 1'b1;
          len_wdata = x_inc;
        end
      end
      KIND_NEWLINE: begin
        row_end   = 1'b1;
        len_wdata = LEN_W'(cur_x_r);
      end
      KIND_READ: begin
        use_mem    = rd_hit;
        fixed_char = SPACE_CODE;
      end
      KIND_READ_OOR: begin
        fixed_char = '0;
      end
    endcase
  end

  always_comb begin
    cur_x_nxt    = cur_x_r;
    cur_y_nxt    = cur_y_r;
    row_base_nxt = row_base_r;
    clear        = 1'b0;
    if (wr_char) begin
      cur_x_nxt = COL_W'(x_inc);
    end
    if (row_end) begin
      cur_x_nxt = '0;
      if (y_inc == ROWC_W'(ROWS)) begin
        clear        = 1'b1;
        cur_y_nxt    = '0;
        row_base_nxt = '0;
      end else begin
        cur_y_nxt    = ROW_W'(y_inc);
        row_base_nxt = ADDR_W'(int'(row_base_r) + COLUMNS);
      end
    end
  end

  assign ram_we = q_pop && wr_char;
  assign ram_re = q_pop && use_mem;

  tcw_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CELLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (row_base_r + ADDR_W'(cur_x_r)),
    .wdata (q_item.char_code),
    .re    (ram_re),
    .raddr (q_item.rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r    <= '0;
      cur_y_r    <= '0;
      row_base_r <= '0;
      s2_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_x_r    <= cur_x_nxt;
        cur_y_r    <= cur_y_nxt;
        row_base_r <= row_base_nxt;
        s2_valid_r <= 1'b1;
      end else if (out_tready) begin
        s2_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && row_end) begin
      len_r[cur_y_r] <= len_wdata;
    end
    if (q_pop) begin
      s2_x_r       <= cur_x_nxt;
      s2_y_r       <= cur_y_nxt;
      s2_cleared_r <= clear;
      s2_use_mem_r <= use_mem;
      s2_char_r    <= fixed_char;
    end
  end

  assign read_char  = s2_use_mem_r ? ram_rdata : s2_char_r;
  assign out_tvalid = s2_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, s2_cleared_r, read_char,
                       F_ROW_W'(s2_y_r), F_COL_W'(s2_x_r)};

`ifndef SYNTHESIS
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(cur_x_r) < COLUMNS) && (int'(cur_y_r) < ROWS))
    else $error("cursor out of range");

  a_row_base: assert property (@(posedge clk) disable iff (!rst_n)
    int'(row_base_r) == int'(cur_y_r) * COLUMNS)
    else $error("row base out of step with cursor row");

  a_clear_home: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && clear) |=> (cur_x_r == '0) && (cur_y_r == '0))
    else $error("cursor not home after clear");

  a_read_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !out_tready) |=> $stable(ram_rdata))
    else $error("store read data changed under a stalled result");
`endif

endmodule

`default_nettype wire

FILE: design/text_console_writer_top.sv
// ----------------------------------------------------------------------------
// text_console_writer_top
// Character console writer on an 80 by 25 text store with cell readback.
// ----------------------------------------------------------------------------
// Takes one request per clock while the queue has room and returns one result
// per request, in order. A request is registered into the queue, handed to the
// execute stage when it pops, and its result is held in the output register;
// the store's registered read lands together with it. The front end queues up
// to four requests, so a stalled result side does not block input until the
// queue fills. A full-screen clear needs no sweep: each row keeps a
// written-length count, and cells not written since the last clear (or reset)
// read back as spaces.
`default_nettype none

module text_console_writer_top import tcw_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output      logic                   in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // char_code[7:0] read_row[12:8] read_col[19:13]
  input  wire logic                   in_tuser,   // op
  output      logic                   out_tvalid,
  input  wire logic                   out_tready,
  output      logic [OUT_TDATA_W-1:0] out_tdata   // cursor_col[6:0] cursor_row[11:7]
                                                  // read_char[19:12] screen_cleared[20]
);

  logic      q_valid;
  logic      q_pop;
  tcw_item_t q_item;

  tcw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  tcw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text console writer.
// ----------------------------------------------------------------------------
// A shadow copy of the 80x25 character store and cursor predicts every
// result. A short directed pass covers reads at the corners, reads outside
// the screen, the zero and all-ones bytes and newline. Random line-shaped
// traffic follows: short lines, newline runs, lines that wrap at the right
// edge, long text, read bursts and noise. Input gaps and output back-pressure
// change from phase to phase. Results are checked in order, field by field.
`default_nettype none

module tb_top;
  import tcw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_PER_PHASE = 450;
  localparam int IDLE_LIMIT       = 10000;  // covers a full store sweep if one is done
  localparam int TAIL_CYCLES      = 10;

  typedef struct {
    logic [F_COL_W-1:0] col;
    logic [F_ROW_W-1:0] row;
    logic [CHAR_W-1:0]  ch;
    logic               cleared;
  } console_result_t;

  class console_shadow;
    logic [CHAR_W-1:0] screen_mirror [CELLS];
    int unsigned       cur_col;
    int unsigned       cur_row;
    console_result_t   pending_results [$];
    int unsigned       errors;

    function new();
      blank_screen();
      cur_col = 0;
      cur_row = 0;
      errors  = 0;
    endfunction

    function void blank_screen();
      foreach (screen_mirror[i]) screen_mirror[i] = SPACE_CODE;
    endfunction

    // Apply one accepted request to the shadow state and queue its result.
    function void log_request(logic op, logic [CHAR_W-1:0] code,
                              logic [F_ROW_W-1:0] rd_row, logic [F_COL_W-1:0] rd_col);
      console_result_t res;
      res.ch      = '0;
      res.cleared = 1'b0;
      if (op == OP_READ) begin
        if (rd_row < ROWS && rd_col < COLUMNS)
          res.ch = screen_mirror[rd_row * COLUMNS + rd_col];
      end else begin
        if (code == NEWLINE_CODE) begin
          cur_col = 0;
          cur_row++;
        end else begin
          screen_mirror[cur_row * COLUMNS + cur_col] = code;
          cur_col++;
        end
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_row >= ROWS) begin
          blank_screen();
          cur_col     = 0;
          cur_row     = 0;
          res.cleared = 1'b1;
        end
      end
      res.col = cur_col[F_COL_W-1:0];
      res.row = cur_row[F_ROW_W-1:0];
      pending_results.push_back(res);
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] data);
      console_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: expected nothing, got 0x%06h",
                 $time, data);
      end else begin
        want = pending_results.pop_front();
        compare_field("cursor_col", 32'(want.col), 32'(data[6:0]));
        compare_field("cursor_row", 32'(want.row), 32'(data[11:7]));
        compare_field("read_char", 32'(want.ch), 32'(data[19:12]));
        compare_field("screen_cleared", 32'(want.cleared), 32'(data[20]));
      end
    endfunction
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  console_shadow sb = new();
  int unsigned   src_idle_pct  = 0;
  int unsigned   sink_stall_pct = 0;
  int unsigned   items_sent    = 0;
  int unsigned   idle_cycles   = 0;

  always #1 clk = ~clk;

  text_console_writer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // Result side: random back-pressure and in-order checking
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata);
  end

  // Watchdog on cycles where neither side moves a request
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Drive one request and wait for its acceptance. tvalid stays high after
  // acceptance; it is lowered only by the next gap or by a drain.
  task automatic push_request(logic op, logic [CHAR_W-1:0] code,
                              logic [F_ROW_W-1:0] rd_row, logic [F_COL_W-1:0] rd_col);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_TDATA_W - 20){1'b0}}, rd_col, rd_row, code};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.log_request(op, code, rd_row, rd_col);
    items_sent++;
  endtask

  task automatic write_char(logic [CHAR_W-1:0] code);
    push_request(OP_WRITE, code, F_ROW_W'($urandom_range(0, 31)),
                 F_COL_W'($urandom_range(0, 127)));
  endtask

  task automatic read_cell(logic [F_ROW_W-1:0] rd_row, logic [F_COL_W-1:0] rd_col);
    push_request(OP_READ, CHAR_W'($urandom_range(0, 255)), rd_row, rd_col);
  endtask

  // Hold input until every outstanding result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic random_sequence();
    int unsigned kind;
    int unsigned n;
    int unsigned r;
    logic [CHAR_W-1:0] code;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      // short line ended by newline
      n = $urandom_range(0, 6);
      repeat (n) write_char(CHAR_W'($urandom_range(0, 255)));
      write_char(NEWLINE_CODE);
    end else if (kind < 45) begin
      // run of newlines, often crosses the bottom row
      n = $urandom_range(1, 30);
      repeat (n) write_char(NEWLINE_CODE);
    end else if (kind < 60) begin
      // fill up to the right edge so the cursor wraps
      n = COLUMNS - sb.cur_col;
      repeat (n) begin
        code = CHAR_W'($urandom_range(0, 255));
        if (code == NEWLINE_CODE) code = SPACE_CODE;
        write_char(code);
      end
    end else if (kind < 70) begin
      n = $urandom_range(40, 200);
      repeat (n) write_char(CHAR_W'($urandom_range(0, 255)));
    end else if (kind < 90) begin
      n = $urandom_range(1, 8);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 10)
          read_cell(F_ROW_W'($urandom_range(0, 31)), F_COL_W'($urandom_range(0, 127)));
        else if (r < 50)
          read_cell(F_ROW_W'(sb.cur_row), F_COL_W'($urandom_range(0, COLUMNS - 1)));
        else
          read_cell(F_ROW_W'($urandom_range(0, ROWS - 1)),
                    F_COL_W'($urandom_range(0, COLUMNS - 1)));
      end
    end else begin
      n = $urandom_range(1, 5);
      repeat (n)
        push_request(1'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 255)),
                     F_ROW_W'($urandom_range(0, 31)), F_COL_W'($urandom_range(0, 127)));
    end
  endtask

  initial begin
    int unsigned goal;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: corners, out-of-screen reads, byte extremes, newline
    read_cell(0, 0);
    read_cell(F_ROW_W'(ROWS - 1), F_COL_W'(COLUMNS - 1));
    read_cell(F_ROW_W'(ROWS), 0);
    read_cell(0, F_COL_W'(COLUMNS));
    read_cell(31, 127);
    write_char(8'h00);
    write_char(8'hFF);
    write_char(SPACE_CODE);
    push_request(OP_WRITE, 8'h55, 31, 127);
    write_char(NEWLINE_CODE);
    write_char(8'h7F);
    write_char(8'hAA);
    read_cell(0, 0);
    read_cell(0, 1);
    read_cell(0, 3);
    read_cell(1, 0);
    read_cell(1, 1);
    read_cell(0, F_COL_W'(COLUMNS - 1));
    read_cell(F_ROW_W'(ROWS - 1), 0);
    write_char(NEWLINE_CODE);
    read_cell(2, 0);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      unique case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 49; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 49; end
        default: begin src_idle_pct = 29; sink_stall_pct = 29; end
      endcase
      goal = items_sent + RANDOM_PER_PHASE;
      while (items_sent < goal) random_sequence();
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
